>>> design/qspm_pkg.sv
// ----------------------------------------------------------------------------
// qspm_pkg
// Shared types and constants of the quaternion, scale and position to model
// matrix pipeline.
// ----------------------------------------------------------------------------
package qspm_pkg;

  localparam int SLOT_W   = 10;
  localparam int FRAME_W  = 32;
  localparam int COMP_W   = 16;   // quaternion and scale components
  localparam int POS_W    = 32;   // Q16.16 positions and matrix entries
  localparam int PROD_W   = 32;   // Q2.30 quaternion products
  localparam int ROT_W    = 34;   // rotation terms in Q.30
  localparam int SPROD_W  = ROT_W + COMP_W;   // rotation times scale, Q.42
  localparam int FRAC_SHIFT = 26;             // Q.42 to Q16.16

  localparam logic signed [ROT_W-1:0]     ONE_Q30    = ROT_W'(64'sd1 <<< 30);
  localparam logic signed [SPROD_W:0]     ROUND_BIAS = (SPROD_W + 1)'(64'sd1 <<< 25);
  localparam logic signed [POS_W-1:0]     ONE_Q16    = 32'sd65536;
  localparam logic signed [POS_W-1:0]     ZERO_Q16   = 32'sd0;

  // Quaternion component positions.
  localparam int Q_R = 0;
  localparam int Q_X = 1;
  localparam int Q_Y = 2;
  localparam int Q_Z = 3;

  // Product positions.
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int P_RX = 6;
  localparam int P_RY = 7;
  localparam int P_RZ = 8;

  // Column codes.
  localparam logic [1:0] COL_FIRST = 2'd0;
  localparam logic [1:0] COL_POS   = 2'd3;

  // Fields that ride along the pipeline untouched.
  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic [2:0][POS_W-1:0]   pos;     // x in [0]
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic [2:0][COMP_W-1:0]  scl;     // x in [0]
    logic [3:0][COMP_W-1:0]  quat;    // r in [0]
  } xform_t;

  typedef struct packed {
    side_t                   side;
    logic [2:0][COMP_W-1:0]  scl;
    logic [8:0][PROD_W-1:0]  prod;
  } prod_t;

  // Rotation terms, entry c*3+k is column c, row k.
  typedef struct packed {
    side_t                   side;
    logic [2:0][COMP_W-1:0]  scl;
    logic [8:0][ROT_W-1:0]   rot;
  } rot_t;

  typedef struct packed {
    side_t                   side;
    logic [8:0][SPROD_W-1:0] sprod;
  } sprod_t;

  typedef struct packed {
    side_t                   side;
    logic [8:0][POS_W-1:0]   elem;
  } mat_t;

endpackage

>>> design/qspm_rotation.sv
// ----------------------------------------------------------------------------
// qspm_rotation
// Two pipeline stages: quaternion component products, then the nine
// rotation matrix terms in Q.30.
// ----------------------------------------------------------------------------
module qspm_rotation (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  qspm_pkg::xform_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output qspm_pkg::rot_t   dn_data
);

  function automatic logic signed [qspm_pkg::PROD_W-1:0] smul(
    logic signed [qspm_pkg::COMP_W-1:0] a,
    logic signed [qspm_pkg::COMP_W-1:0] b
  );
    return a * b;
  endfunction

  // 1 - 2*(a+b)
  function automatic logic [qspm_pkg::ROT_W-1:0] diag_term(
    logic signed [qspm_pkg::PROD_W-1:0] a,
    logic signed [qspm_pkg::PROD_W-1:0] b
  );
    logic signed [qspm_pkg::ROT_W-1:0] s;
    s = qspm_pkg::ROT_W'(a) + qspm_pkg::ROT_W'(b);
    return qspm_pkg::ONE_Q30 - (s <<< 1);
  endfunction

  // 2*(a+b) or 2*(a-b)
  function automatic logic [qspm_pkg::ROT_W-1:0] off_term(
    logic signed [qspm_pkg::PROD_W-1:0] a,
    logic signed [qspm_pkg::PROD_W-1:0] b,
    logic                               sub
  );
    logic signed [qspm_pkg::ROT_W-1:0] s;
    if (sub) begin
      s = qspm_pkg::ROT_W'(a) - qspm_pkg::ROT_W'(b);
    end else begin
      s = qspm_pkg::ROT_W'(a) + qspm_pkg::ROT_W'(b);
    end
    return s <<< 1;
  endfunction

  logic             prod_valid_r;
  qspm_pkg::prod_t  prod_r;
  qspm_pkg::prod_t  prod_nxt;
  logic             prod_ready;
  logic             rot_valid_r;
  qspm_pkg::rot_t   rot_r;
  qspm_pkg::rot_t   rot_nxt;
  logic             rot_ready;

  assign rot_ready  = !rot_valid_r || dn_ready;
  assign prod_ready = !prod_valid_r || rot_ready;
  assign up_ready   = prod_ready;

  always_comb begin
    logic signed [qspm_pkg::COMP_W-1:0] r, x, y, z;
    r = up_data.quat[qspm_pkg::Q_R];
    x = up_data.quat[qspm_pkg::Q_X];
    y = up_data.quat[qspm_pkg::Q_Y];
    z = up_data.quat[qspm_pkg::Q_Z];
    prod_nxt.side = up_data.side;
    prod_nxt.scl  = up_data.scl;
    prod_nxt.prod[qspm_pkg::P_XX] = smul(x, x);
    prod_nxt.prod[qspm_pkg::P_YY] = smul(y, y);
    prod_nxt.prod[qspm_pkg::P_ZZ] = smul(z, z);
    prod_nxt.prod[qspm_pkg::P_XY] = smul(x, y);
    prod_nxt.prod[qspm_pkg::P_XZ] = smul(x, z);
    prod_nxt.prod[qspm_pkg::P_YZ] = smul(y, z);
    prod_nxt.prod[qspm_pkg::P_RX] = smul(r, x);
    prod_nxt.prod[qspm_pkg::P_RY] = smul(r, y);
    prod_nxt.prod[qspm_pkg::P_RZ] = smul(r, z);
  end

  always_comb begin
    logic signed [qspm_pkg::PROD_W-1:0] xx, yy, zz, xy, xz, yz, rx, ry, rz;
    xx = prod_r.prod[qspm_pkg::P_XX];
    yy = prod_r.prod[qspm_pkg::P_YY];
    zz = prod_r.prod[qspm_pkg::P_ZZ];
    xy = prod_r.prod[qspm_pkg::P_XY];
    xz = prod_r.prod[qspm_pkg::P_XZ];
    yz = prod_r.prod[qspm_pkg::P_YZ];
    rx = prod_r.prod[qspm_pkg::P_RX];
    ry = prod_r.prod[qspm_pkg::P_RY];
    rz = prod_r.prod[qspm_pkg::P_RZ];
    rot_nxt.side   = prod_r.side;
    rot_nxt.scl    = prod_r.scl;
    rot_nxt.rot[0] = diag_term(yy, zz);
    rot_nxt.rot[1] = off_term(xy, rz, 1'b0);
    rot_nxt.rot[2] = off_term(xz, ry, 1'b1);
    rot_nxt.rot[3] = off_term(xy, rz, 1'b1);
    rot_nxt.rot[4] = diag_term(xx, zz);
    rot_nxt.rot[5] = off_term(yz, rx, 1'b0);
    rot_nxt.rot[6] = off_term(xz, ry, 1'b0);
    rot_nxt.rot[7] = off_term(yz, rx, 1'b1);
    rot_nxt.rot[8] = diag_term(xx, yy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      rot_valid_r  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= up_valid;
      end
      if (rot_ready) begin
        rot_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && up_valid) begin
      prod_r <= prod_nxt;
    end
    if (rot_ready && prod_valid_r) begin
      rot_r <= rot_nxt;
    end
  end

  assign dn_valid = rot_valid_r;
  assign dn_data  = rot_r;

endmodule

>>> design/qspm_scale.sv
// ----------------------------------------------------------------------------
// qspm_scale
// Two pipeline stages: rotation terms times the column scale into Q.42,
// then rounding to Q16.16.
// ----------------------------------------------------------------------------
module qspm_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  qspm_pkg::rot_t   up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output qspm_pkg::mat_t   dn_data
);

  logic              mul_valid_r;
  qspm_pkg::sprod_t  mul_r;
  qspm_pkg::sprod_t  mul_nxt;
  logic              mul_ready;
  logic              rnd_valid_r;
  qspm_pkg::mat_t    rnd_r;
  qspm_pkg::mat_t    rnd_nxt;
  logic              rnd_ready;

  assign rnd_ready = !rnd_valid_r || dn_ready;
  assign mul_ready = !mul_valid_r || rnd_ready;
  assign up_ready  = mul_ready;

  always_comb begin
    logic signed [qspm_pkg::ROT_W-1:0]   rot;
    logic signed [qspm_pkg::COMP_W-1:0]  scl;
    logic signed [qspm_pkg::SPROD_W-1:0] p;
    mul_nxt.side  = up_data.side;
    mul_nxt.sprod = '0;
    for (int i = 0; i < 9; i++) begin
      rot = up_data.rot[i];
      scl = up_data.scl[i / 3];
      p   = rot * scl;
      mul_nxt.sprod[i] = p;
    end
  end

  // Entries stay well inside 2^23 for any input, so the shifted value
  // always fits the Q16.16 range and no clipping is required.
  always_comb begin
    logic signed [qspm_pkg::SPROD_W:0] t;
    rnd_nxt.side = mul_r.side;
    rnd_nxt.elem = '0;
    for (int i = 0; i < 9; i++) begin
      t = (qspm_pkg::SPROD_W + 1)'($signed(mul_r.sprod[i])) + qspm_pkg::ROUND_BIAS;
      rnd_nxt.elem[i] = qspm_pkg::POS_W'(t >>> qspm_pkg::FRAC_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      rnd_valid_r <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_r <= up_valid;
      end
      if (rnd_ready) begin
        rnd_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && up_valid) begin
      mul_r <= mul_nxt;
    end
    if (rnd_ready && mul_valid_r) begin
      rnd_r <= rnd_nxt;
    end
  end

  assign dn_valid = rnd_valid_r;
  assign dn_data  = rnd_r;

endmodule

>>> design/qspm_column_out.sv
// ----------------------------------------------------------------------------
// qspm_column_out
// Holds one finished matrix and sends it out one column per transfer.
// ----------------------------------------------------------------------------
module qspm_column_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  qspm_pkg::mat_t                up_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qspm_pkg::SLOT_W-1:0]   out_slot,
  output logic [1:0]                    out_col,
  output logic [2:0][qspm_pkg::POS_W-1:0] out_rows,
  output logic [qspm_pkg::POS_W-1:0]    out_row3,
  output logic                          out_last
);

  logic            valid_r;
  logic [1:0]      col_r;
  qspm_pkg::mat_t  mat_r;
  logic            last;
  logic            take;

  assign last     = (col_r == qspm_pkg::COL_POS);
  assign up_ready = !valid_r || (out_ready && last);
  assign take     = up_ready && up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      col_r   <= qspm_pkg::COL_FIRST;
    end else if (take) begin
      valid_r <= 1'b1;
      col_r   <= qspm_pkg::COL_FIRST;
    end else if (valid_r && out_ready) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mat_r <= up_data;
    end
  end

  always_comb begin
    out_rows = '0;
    if (last) begin
      out_rows = mat_r.side.pos;
    end else begin
      for (int k = 0; k < 3; k++) begin
        out_rows[k] = mat_r.elem[3 * col_r + k];
      end
    end
  end

  assign out_valid = valid_r;
  assign out_slot  = mat_r.side.slot;
  assign out_col   = col_r;
  assign out_row3  = last ? qspm_pkg::ONE_Q16 : qspm_pkg::ZERO_Q16;
  assign out_last  = last;

endmodule

>>> design/quat_scale_pos_to_matrix.sv
// ----------------------------------------------------------------------------
// quat_scale_pos_to_matrix
// Builds the column-major 4x4 model matrix T*R*S of one entity transform.
// ----------------------------------------------------------------------------
// Input channel in_*: one entity transform per transfer. Items whose
// entity_frame differs from current_frame, or whose model_slot is not below
// SLOT_COUNT, are consumed and produce nothing.
// Output channel out_*: four transfers per matching item, columns 0 to 3 in
// order; out_tuser carries the column number, out_tlast marks column 3.
// Configuration: cfg_wr_en writes cfg_wr_data into current_frame; write it
// only while the block is idle.
// Registers: the input register, loaded by the transfer itself, then
// products, rotation terms, scale multiply, rounding and the column register.
// The column register sends one column per cycle while out_tready is high
// and can take the next matching item while its last column goes out;
// dropped items flow at one per cycle while in_tready is high.
// Reset clears all valid bits and current_frame. When the receiver stalls,
// the column on the output holds and the pipeline fills behind it, then
// in_tready falls.
// ----------------------------------------------------------------------------
module quat_scale_pos_to_matrix #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // model_slot, entity_frame, quat_r, quat_x, quat_y, quat_z, scale_x,
  // scale_y, scale_z, pos_x, pos_y, pos_z, 6 zero bits
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_slot, elem_row0, elem_row1, elem_row2, elem_row3, 6 zero bits
  output logic [143:0] out_tdata,
  // column_index
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  logic [qspm_pkg::FRAME_W-1:0] current_frame_r;
  logic                         in_valid_r;
  qspm_pkg::xform_t             in_r;
  qspm_pkg::xform_t             in_nxt;
  logic                         match;
  logic                         rot_ready;
  logic                         rot_valid;
  qspm_pkg::rot_t               rot_data;
  logic                         scl_ready;
  logic                         mat_valid;
  qspm_pkg::mat_t               mat_data;
  logic                         col_ready;
  logic [qspm_pkg::SLOT_W-1:0]  col_slot;
  logic [2:0][qspm_pkg::POS_W-1:0] col_rows;
  logic [qspm_pkg::POS_W-1:0]   col_row3;

  always_comb begin
    in_nxt.side.slot   = in_tdata[9:0];
    in_nxt.quat[qspm_pkg::Q_R] = in_tdata[57:42];
    in_nxt.quat[qspm_pkg::Q_X] = in_tdata[73:58];
    in_nxt.quat[qspm_pkg::Q_Y] = in_tdata[89:74];
    in_nxt.quat[qspm_pkg::Q_Z] = in_tdata[105:90];
    in_nxt.scl[0]      = in_tdata[121:106];
    in_nxt.scl[1]      = in_tdata[137:122];
    in_nxt.scl[2]      = in_tdata[153:138];
    in_nxt.side.pos[0] = in_tdata[185:154];
    in_nxt.side.pos[1] = in_tdata[217:186];
    in_nxt.side.pos[2] = in_tdata[249:218];
  end

  assign match = (in_tdata[41:10] == current_frame_r) &&
                 (32'(in_tdata[9:0]) < SLOT_COUNT);

  assign in_tready = !in_valid_r || rot_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_frame_r <= '0;
      in_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        current_frame_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid && match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r <= in_nxt;
    end
  end

  qspm_rotation u_rotation (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid_r),
    .up_ready (rot_ready),
    .up_data  (in_r),
    .dn_valid (rot_valid),
    .dn_ready (scl_ready),
    .dn_data  (rot_data)
  );

  qspm_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (rot_valid),
    .up_ready (scl_ready),
    .up_data  (rot_data),
    .dn_valid (mat_valid),
    .dn_ready (col_ready),
    .dn_data  (mat_data)
  );

  qspm_column_out u_column_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (mat_valid),
    .up_ready  (col_ready),
    .up_data   (mat_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_slot  (col_slot),
    .out_col   (out_tuser),
    .out_rows  (col_rows),
    .out_row3  (col_row3),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, col_row3, col_rows[2], col_rows[1], col_rows[0], col_slot};

endmodule

>>> design/qspm_checker.sv
// ----------------------------------------------------------------------------
// qspm_checker
// Port-level checks of the matrix column stream, bound to the top level.
// ----------------------------------------------------------------------------
module qspm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // The last column is exactly column 3.
  a_last_is_col3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == qspm_pkg::COL_POS)))
    else $error("tlast does not match column 3");

  // The bottom row is 1.0 on the position column and 0 elsewhere.
  a_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[137:106] ==
                    (out_tlast ? qspm_pkg::ONE_Q16 : qspm_pkg::ZERO_Q16)))
    else $error("bottom row entry wrong");

  // A matrix is sent without gaps: the next column follows at once.
  a_next_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tuser == 2'($past(out_tuser) + 2'd1)))
    else $error("column sequence broken");

  // All columns of a matrix carry the same slot.
  a_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tdata[9:0] == $past(out_tdata[9:0])))
    else $error("slot changed within a matrix");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output changed");

endmodule

bind quat_scale_pos_to_matrix qspm_checker u_qspm_checker (.*);
